>>> hdl/override_gaze_blender_top_assert.svh
// assertion macros for the override gaze blender checker
// depends on nothing; expects clk and arst_n in scope where used
`ifndef OVERRIDE_GAZE_BLENDER_TOP_ASSERT_SVH
`define OVERRIDE_GAZE_BLENDER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OGB_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ogb assertion failed");

// next-cycle implication, disabled during reset
`define OGB_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ogb assertion failed");

`endif

>>> hdl/ogb_pkg.sv
// shared types and constants for the override gaze blender
// no dependencies
package ogb_pkg;

	localparam logic [16:0]        BLEND_ONE = 17'h10000;
	localparam logic signed [15:0] GAZE_ONE  = 16'sd16384;

	// reset values of the configuration registers
	localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
	localparam logic [16:0] FAST_STEP_RST = 17'd13107;
	localparam logic [16:0] SLOW_STEP_RST = 17'd6554;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_OVERRIDE = 2'd1,
		CMD_LOCAL    = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		CFG_TIMEOUT   = 2'd0,
		CFG_FAST_STEP = 2'd1,
		CFG_SLOW_STEP = 2'd2
	} cfg_idx_e;

	typedef struct packed {
		logic [1:0]        cmd;
		logic signed [15:0] gaze_x;
		logic signed [15:0] gaze_y;
		logic [9:0]        elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic              mode;
		logic [16:0]       blend;
	} out_item_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [16:0] fast_step;
		logic [16:0] slow_step;
	} cfg_t;

endpackage

>>> hdl/ogb_lerp.sv
// one axis of the blend: cur + (tgt - cur) * b, rounded, clamped to +-1.0
// depends on ogb_pkg
module ogb_lerp (
	input  logic signed [15:0] cur,
	input  logic signed [15:0] tgt,
	input  logic [16:0]        b,
	output logic signed [15:0] res
);

	logic signed [16:0] diff;
	logic signed [17:0] b_s;
	logic signed [34:0] prod;
	logic signed [35:0] sum;
	logic signed [19:0] q;

	always_comb begin
		diff = $signed({tgt[15], tgt}) - $signed({cur[15], cur});
		b_s  = $signed({1'b0, b});
		prod = diff * b_s;
		// cur scaled by one, plus half an lsb for round half up
		sum  = $signed({{4{cur[15]}}, cur, 16'd0}) + $signed({prod[34], prod})
			+ 36'sd32768;
		q    = $signed(sum[35:16]);
		if (q > 20'(ogb_pkg::GAZE_ONE)) begin
			res = ogb_pkg::GAZE_ONE;
		end else if (q < -20'(ogb_pkg::GAZE_ONE)) begin
			res = -ogb_pkg::GAZE_ONE;
		end else begin
			res = q[15:0];
		end
	end

endmodule

>>> hdl/ogb_cfg.sv
// configuration registers: timeout and the two blend steps
// depends on ogb_pkg
module ogb_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [16:0]      cfg_data,
	output ogb_pkg::cfg_t    cfg
);

	ogb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms <= ogb_pkg::TIMEOUT_RST;
			cfg_q.fast_step  <= ogb_pkg::FAST_STEP_RST;
			cfg_q.slow_step  <= ogb_pkg::SLOW_STEP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ogb_pkg::CFG_TIMEOUT: begin
					cfg_q.timeout_ms <= cfg_data[15:0];
				end
				ogb_pkg::CFG_FAST_STEP: begin
					cfg_q.fast_step <= cfg_data;
				end
				ogb_pkg::CFG_SLOW_STEP: begin
					cfg_q.slow_step <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hdl/ogb_core.sv
// blender state and per-item update; the state registers are the result
// depends on ogb_pkg, ogb_lerp
module ogb_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  ogb_pkg::in_item_t    item,
	input  ogb_pkg::cfg_t        cfg,
	output ogb_pkg::out_item_t   res
);

	logic               mode_q;
	logic [16:0]        blend_q;
	logic signed [15:0] out_x_q;
	logic signed [15:0] out_y_q;
	logic signed [15:0] ovr_x_q;
	logic signed [15:0] ovr_y_q;
	logic [15:0]        since_q;

	logic [16:0]        since_sum;
	logic [15:0]        since_sat;
	logic               lapse;
	logic               tick_mode;
	logic [16:0]        blend_base;
	logic [16:0]        step;
	logic [17:0]        blend_sum;
	logic [16:0]        tick_blend;
	logic signed [15:0] tgt_x;
	logic signed [15:0] tgt_y;
	logic signed [15:0] lerp_x;
	logic signed [15:0] lerp_y;

	always_comb begin
		since_sum  = {1'b0, since_q} + {7'd0, item.elapsed_ms};
		since_sat  = since_sum[16] ? 16'hFFFF : since_sum[15:0];
		// override lapses once the timer passes the timeout
		lapse      = mode_q && (since_sat > cfg.timeout_ms);
		tick_mode  = mode_q && !lapse;
		blend_base = lapse ? 17'd0 : blend_q;
		step       = tick_mode ? cfg.fast_step : cfg.slow_step;
		blend_sum  = {1'b0, blend_base} + {1'b0, step};
		tick_blend = (blend_sum > {1'b0, ogb_pkg::BLEND_ONE}) ? ogb_pkg::BLEND_ONE
			: blend_sum[16:0];
		tgt_x      = tick_mode ? ovr_x_q : item.gaze_x;
		tgt_y      = tick_mode ? ovr_y_q : item.gaze_y;
	end

	ogb_lerp u_lerp_x (
		.cur (out_x_q),
		.tgt (tgt_x),
		.b   (tick_blend),
		.res (lerp_x)
	);

	ogb_lerp u_lerp_y (
		.cur (out_y_q),
		.tgt (tgt_y),
		.b   (tick_blend),
		.res (lerp_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			blend_q <= 17'd0;
			out_x_q <= 16'sd0;
			out_y_q <= 16'sd0;
			ovr_x_q <= 16'sd0;
			ovr_y_q <= 16'sd0;
			since_q <= 16'd0;
		end else if (advance) begin
			case (item.cmd)
				ogb_pkg::CMD_TICK: begin
					since_q <= since_sat;
					mode_q  <= tick_mode;
					blend_q <= tick_blend;
					out_x_q <= lerp_x;
					out_y_q <= lerp_y;
				end
				ogb_pkg::CMD_OVERRIDE: begin
					ovr_x_q <= item.gaze_x;
					ovr_y_q <= item.gaze_y;
					since_q <= 16'd0;
					if (!mode_q) begin
						mode_q  <= 1'b1;
						blend_q <= 17'd0;
					end
				end
				ogb_pkg::CMD_LOCAL: begin
					if (mode_q) begin
						mode_q  <= 1'b0;
						blend_q <= ogb_pkg::BLEND_ONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.out_x = out_x_q;
	assign res.out_y = out_y_q;
	assign res.mode  = mode_q;
	assign res.blend = blend_q;

endmodule

>>> hdl/override_gaze_blender_top.sv
// top level of the override gaze blender: input stage, core, config port
// depends on ogb_pkg, ogb_cfg, ogb_core (and ogb_lerp below it)
//
// usage
// - item channel (item_valid/item_ready/item_data): one command per item,
//   a tick with local gaze and elapsed ms, an override target, or force local
// - result channel (res_valid/res_ready/res_data): exactly one result per
//   item, the blended gaze, mode and blend factor after that item
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 timeout ms, 1 fast step, 2 slow step, index 3 is dropped;
//   write only while no item is in flight
// - result timing: an accepted item waits in the input register until the
//   result slot is free; res_valid rises as it enters the state registers
// - throughput: one item per cycle unless stalled; the item register feeds
//   one pass of timer, blend and lerp logic (one 17x18 multiply per axis)
//   straight into the state registers, which are also the result register
// - stall: while a result waits, the next item is still taken into the
//   input register and held there; item_ready drops only when both are full
// - reset: asynchronous, clears mode, blend, outputs, timer and override
//   target to zero and loads the register defaults (2000 ms, 0.2, 0.1)
module override_gaze_blender_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ogb_pkg::in_item_t   item_data,
	output logic                res_valid,
	input  logic                res_ready,
	output ogb_pkg::out_item_t  res_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data
);

	logic              valid_s1;
	ogb_pkg::in_item_t item_s1;
	logic              res_valid_q;
	logic              advance;
	ogb_pkg::cfg_t     cfg;

	// the staged item moves into the state when the result slot is free
	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign item_ready = !valid_s1 || advance;
	assign res_valid  = res_valid_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item_data;
		end
	end

	// result valid tracks the state registers holding an undelivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	ogb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ogb_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_data)
	);

endmodule

>>> hdl/ogb_checker.sv
// port-level checks for the override gaze blender, bound to the top level
// depends on ogb_pkg and override_gaze_blender_top_assert.svh
`include "override_gaze_blender_top_assert.svh"

module ogb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_ready,
	input logic                res_valid,
	input logic                res_ready,
	input ogb_pkg::out_item_t  res_data
);

	logic x_in_range;
	logic y_in_range;

	assign x_in_range = (res_data.out_x <= ogb_pkg::GAZE_ONE)
		&& (res_data.out_x >= -ogb_pkg::GAZE_ONE);
	assign y_in_range = (res_data.out_y <= ogb_pkg::GAZE_ONE)
		&& (res_data.out_y >= -ogb_pkg::GAZE_ONE);

	// a stalled result holds
	`OGB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
	// with no result waiting the block always takes an item
	`OGB_ASSERT_IMPL(a_ready_when_empty, !res_valid, item_ready)
	// blend never exceeds one
	`OGB_ASSERT_IMPL(a_blend_range, res_valid, res_data.blend <= ogb_pkg::BLEND_ONE)
	// outputs stay within plus minus one
	`OGB_ASSERT_IMPL(a_out_range, res_valid, x_in_range && y_in_range)

endmodule

bind override_gaze_blender_top ogb_checker u_ogb_checker (.*);

>>> tb/tb_override_gaze_blender_top.sv
// self-checking testbench for override_gaze_blender_top: a directed table, then random phases
// under several register settings; results are checked against an in-bench blend predictor
// depends on ogb_pkg and the override_gaze_blender_top rtl
module tb_override_gaze_blender_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ogb_pkg::*;

	// unused command code and unused register index, both must be ignored by the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	localparam int PHASE_ITEMS = 125;       // counted items per random phase
	localparam int N_PHASES    = 6;
	localparam int SETTLE      = 4;         // tail cycles
	localparam int HOLD_LEN    = 64;        // long receiver hold-off
	localparam int LIMIT_NS    = 1_000_000;

	// one row of the directed table; want fields only matter when typed is set
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] gx;
		logic [15:0] gy;
		logic [9:0]  el;
		logic        typed;
		logic [15:0] wx;
		logic [15:0] wy;
		logic        wm;
		logic [16:0] wb;
	} stim_row_t;

	localparam int N_ROWS = 23;

	// runs on the reset register values: timeout 2000, fast 0.2, slow 0.1
	localparam stim_row_t DIR_ROWS [0:N_ROWS-1] = '{
		// unused code and force-local while already local change nothing
		'{CMD_UNUSED,   16'h7fff, 16'h8000, 10'h3ff, 1'b1, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_LOCAL,    16'h8000, 16'h7fff, 10'h3ff, 1'b1, 16'h0, 16'h0, 1'b0, 17'd0},
		// ten slow ticks toward the extreme corner, blend saturates on the tenth
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h000, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h7fff, 16'h8000, 10'h3ff, 1'b1, GAZE_ONE, -GAZE_ONE, 1'b0,
			BLEND_ONE},
		// override enters override mode at zero blend, output holds
		'{CMD_OVERRIDE, 16'h8000, 16'h7fff, 10'h3ff, 1'b1, GAZE_ONE, -GAZE_ONE, 1'b1, 17'd0},
		// timer lands exactly on the timeout, then one past it
		'{CMD_TICK,     16'h0000, 16'h0000, 10'd1000, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h0001, 16'hffff, 10'd1000, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h2000, 16'he000, 10'd1,    1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		// override from local, then a second override while in override
		'{CMD_OVERRIDE, 16'h4000, 16'hc000, 10'h000, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_OVERRIDE, 16'h1234, 16'hedcb, 10'h3ff, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h0000, 16'h0000, 10'h000, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		// force local from override sets full blend, next tick snaps to local gaze
		'{CMD_LOCAL,    16'h0000, 16'h0000, 10'h000, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'hffff, 16'h0001, 10'h000, 1'b1, 16'hffff, 16'h0001, 1'b0,
			BLEND_ONE},
		'{CMD_UNUSED,   16'h5555, 16'haaaa, 10'h155, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0},
		'{CMD_TICK,     16'h5555, 16'haaaa, 10'h2aa, 1'b0, 16'h0, 16'h0, 1'b0, 17'd0}
	};

	// dut signals, every input known from time zero
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	in_item_t   item_data = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	out_item_t  res_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_TIMEOUT;
	logic [16:0] cfg_data = '0;

	// predictor copy of the blender state and registers
	logic               mode_q;
	logic [16:0]        blend_q;
	logic signed [15:0] outx_q, outy_q;
	logic signed [15:0] locx_q, locy_q;
	logic signed [15:0] ovrx_q, ovry_q;
	logic [15:0]        since_q;
	logic [15:0]        timeout_r;
	logic [16:0]        fast_r, slow_r;

	// blended gaze results still owed by the block, oldest first
	out_item_t blended_due [$];

	int n_errors   = 0;
	int n_items    = 0;
	int n_checked  = 0;
	int n_lapses   = 0;
	int n_settings = 0;
	int send_calm  = 0;
	int recv_calm  = 0;

	override_gaze_blender_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_data  (item_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// one axis of the lerp: round to nearest with ties up, i.e. floor after adding half
	function automatic logic signed [15:0] lerp_q14(logic signed [15:0] cur,
		logic signed [15:0] tgt, logic [16:0] b);
		longint acc;
		longint q;
		acc = longint'(cur) * (longint'(BLEND_ONE) - longint'(b))
			+ longint'(tgt) * longint'(b) + 64'sd32768;
		q = acc >>> 16;
		if (q > longint'(GAZE_ONE))
			q = longint'(GAZE_ONE);
		if (q < -longint'(GAZE_ONE))
			q = -longint'(GAZE_ONE);
		return 16'(q);
	endfunction

	// advance the predictor by one item and return the state it reports
	function automatic out_item_t blend_next(in_item_t it);
		logic [16:0] tsum;
		logic [17:0] bsum;
		out_item_t r;
		case (it.cmd)
			CMD_TICK: begin
				locx_q = it.gaze_x;
				locy_q = it.gaze_y;
				tsum = {1'b0, since_q} + 17'(it.elapsed_ms);
				since_q = tsum[16] ? 16'hffff : tsum[15:0];
				// override lapses once the timer passes the timeout
				if (mode_q && since_q > timeout_r) begin
					mode_q = 1'b0;
					blend_q = '0;
					n_lapses++;
				end
				bsum = 18'(blend_q) + 18'(mode_q ? fast_r : slow_r);
				blend_q = (bsum > 18'(BLEND_ONE)) ? BLEND_ONE : bsum[16:0];
				outx_q = lerp_q14(outx_q, mode_q ? ovrx_q : locx_q, blend_q);
				outy_q = lerp_q14(outy_q, mode_q ? ovry_q : locy_q, blend_q);
			end
			CMD_OVERRIDE: begin
				ovrx_q = it.gaze_x;
				ovry_q = it.gaze_y;
				if (!mode_q) begin
					mode_q = 1'b1;
					blend_q = '0;
				end
				since_q = '0;
			end
			CMD_LOCAL: begin
				if (mode_q) begin
					mode_q = 1'b0;
					blend_q = BLEND_ONE;
				end
			end
			default: ;
		endcase
		r.out_x = outx_q;
		r.out_y = outy_q;
		r.mode  = mode_q;
		r.blend = blend_q;
		return r;
	endfunction

	// idle gap for one item, drawn at random, with occasional calm stretches of no idling
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(8, 30);
		return $urandom_range(0, 5);
	endfunction

	// gaze values: full range, within plus minus one, extremes, near zero
	function automatic logic [15:0] rand_gaze();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 32768)) - 16'd16384;
			2: begin
				case ($urandom_range(0, 6))
					0: return 16'h8000;
					1: return 16'hc000;
					2: return 16'hffff;
					3: return 16'h0000;
					4: return 16'h0001;
					5: return 16'h4000;
					default: return 16'h7fff;
				endcase
			end
			default: return 16'($urandom_range(0, 64)) - 16'd32;
		endcase
	endfunction

	// mostly ticks, weights for override and force-local set per phase
	function automatic in_item_t rand_item(int ovr_w, int loc_w, bit long_el);
		int r;
		in_item_t it;
		r = $urandom_range(0, 99);
		if (r < ovr_w)
			it.cmd = CMD_OVERRIDE;
		else if (r < ovr_w + loc_w)
			it.cmd = CMD_LOCAL;
		else if (r < ovr_w + loc_w + 3)
			it.cmd = CMD_UNUSED;
		else
			it.cmd = CMD_TICK;
		it.gaze_x = rand_gaze();
		it.gaze_y = rand_gaze();
		if (long_el)
			it.elapsed_ms = 10'($urandom_range(800, 1023));
		else if ($urandom_range(0, 3) == 0)
			it.elapsed_ms = 10'($urandom_range(0, 40));
		else
			it.elapsed_ms = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	// offer one item and wait for its handshake; valid stays up when the next gap is zero
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_want);
		int gap;
		out_item_t nxt;
		gap = draw_idle(send_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_data  <= it;
		do @(posedge clk); while (!item_ready);
		nxt = blend_next(it);
		blended_due.push_back(typed ? typed_want : nxt);
		n_items++;
	endtask

	// register write over the cfg channel, mirrored into the predictor
	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TIMEOUT:   timeout_r = val[15:0];
			CFG_FAST_STEP: fast_r = val;
			CFG_SLOW_STEP: slow_r = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drain: stop offering, wait for every owed result, then wait out the settle tail
	task automatic settle();
		item_valid <= 1'b0;
		while (blended_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// main sequence: reset, directed table, random phases, verdict
	initial begin : stimulus
		in_item_t  it;
		out_item_t tw;
		int        ovr_w;
		int        loc_w;
		bit        long_el;
		int        sent;

		// predictor reset state matches the block's reset
		mode_q    = 1'b0;
		blend_q   = '0;
		outx_q    = '0;
		outy_q    = '0;
		locx_q    = '0;
		locy_q    = '0;
		ovrx_q    = '0;
		ovry_q    = '0;
		since_q   = '0;
		timeout_r = TIMEOUT_RST;
		fast_r    = FAST_STEP_RST;
		slow_r    = SLOW_STEP_RST;

		// reset held from time zero, released once
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset register values
		n_settings++;
		for (int i = 0; i < N_ROWS; i++) begin
			it.cmd        = DIR_ROWS[i].cmd;
			it.gaze_x     = DIR_ROWS[i].gx;
			it.gaze_y     = DIR_ROWS[i].gy;
			it.elapsed_ms = DIR_ROWS[i].el;
			tw.out_x      = DIR_ROWS[i].wx;
			tw.out_y      = DIR_ROWS[i].wy;
			tw.mode       = DIR_ROWS[i].wm;
			tw.blend      = DIR_ROWS[i].wb;
			send_item(it, DIR_ROWS[i].typed, tw);
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			ovr_w   = 15;
			loc_w   = 8;
			long_el = 1'b0;
			case (ph)
				0: begin
					// all registers at zero: immediate lapse, blend never steps
					write_reg(CFG_TIMEOUT, 17'd0);
					write_reg(CFG_FAST_STEP, 17'd0);
					write_reg(CFG_SLOW_STEP, 17'd0);
				end
				1: begin
					// timeout and fast step all bits set, slow step at one: timeout never passed, blend saturates
					write_reg(CFG_TIMEOUT, 17'h1ffff);
					write_reg(CFG_FAST_STEP, 17'h1ffff);
					write_reg(CFG_SLOW_STEP, BLEND_ONE);
					ovr_w   = 1;
					loc_w   = 0;
					long_el = 1'b1;
				end
				2: begin
					// back to defaults, then a write to the unused index must be dropped
					write_reg(CFG_TIMEOUT, 17'(TIMEOUT_RST));
					write_reg(CFG_FAST_STEP, FAST_STEP_RST);
					write_reg(CFG_SLOW_STEP, SLOW_STEP_RST);
					write_reg(CFG_UNUSED, 17'($urandom));
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						write_reg(CFG_TIMEOUT, 17'($urandom_range(0, 5000)));
					else
						write_reg(CFG_TIMEOUT, 17'($urandom));
					if ($urandom_range(0, 2) == 0)
						write_reg(CFG_FAST_STEP, 17'($urandom_range(0, 131071)));
					else
						write_reg(CFG_FAST_STEP, 17'($urandom_range(1000, 30000)));
					if ($urandom_range(0, 2) == 0)
						write_reg(CFG_SLOW_STEP, 17'($urandom_range(0, 131071)));
					else
						write_reg(CFG_SLOW_STEP, 17'($urandom_range(500, 20000)));
				end
			endcase
			n_settings++;

			// the long-timer phase opens in override mode so the timer can saturate there
			if (long_el) begin
				it = rand_item(0, 0, 1'b1);
				it.cmd = CMD_OVERRIDE;
				send_item(it, 1'b0, '0);
			end

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				it = rand_item(ovr_w, loc_w, long_el);
				send_item(it, 1'b0, '0);
				if (it.cmd != CMD_UNUSED)
					sent++;
			end
		end

		settle();

		$display("run covered %0d items under %0d register settings, %0d results checked",
			n_items, n_settings, n_checked);
		$display("override mode lapsed on timeout %0d times", n_lapses);
		if (n_errors == 0 && blended_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver: random ready gaps, two long hold-offs so the block backs up into item_ready
	initial begin : receiver
		int        gap;
		out_item_t got;
		out_item_t want;

		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n_checked == 200 || n_checked == 500)
				gap = HOLD_LEN;
			else
				gap = draw_idle(recv_calm);
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			got = res_data;
			if (blended_due.size() == 0) begin
				$display("%0t: result with nothing expected: x=%0d y=%0d mode=%0d blend=%0d",
					$time, got.out_x, got.out_y, got.mode, got.blend);
				n_errors++;
			end else begin
				want = blended_due.pop_front();
				// field by field against the oldest owed result
				if (got.out_x !== want.out_x || got.out_y !== want.out_y
					|| got.mode !== want.mode || got.blend !== want.blend) begin
					$display("%0t: mismatch, expected x=%0d y=%0d mode=%0d blend=%0d",
						$time, want.out_x, want.out_y, want.mode, want.blend);
					$display("%0t: actual x=%0d y=%0d mode=%0d blend=%0d",
						$time, got.out_x, got.out_y, got.mode, got.blend);
					n_errors++;
				end
			end
			n_checked++;
		end
	end

	// watchdog on a generous fixed time
	initial begin : watchdog
		#LIMIT_NS;
		$display("timeout with %0d results still owed", blended_due.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ogb_pkg.sv
hdl/ogb_lerp.sv
hdl/ogb_cfg.sv
hdl/ogb_core.sv
hdl/override_gaze_blender_top.sv
hdl/ogb_checker.sv
tb/tb_override_gaze_blender_top.sv
